@@ hw/rtl/bti_pkg.sv @@
// bti_pkg: shared types, widths and constants of the bilinear table interpolator
// used by bilinear_table_interpolator_core and bti_checker, no dependencies
package bti_pkg;

  // grid size defaults
  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 128;

  // field widths
  localparam int COORD_W  = 32;
  localparam int VAL_W    = 24;
  localparam int WR_ROW_W = 10;
  localparam int WR_COL_W = 7;
  localparam int FRAC_W   = 16;
  localparam int IDX_W    = 48;              // Q32.16 fractional grid index
  localparam int WGT_W    = FRAC_W + 1;      // weight 0..65536
  localparam int WPROD_W  = 2 * FRAC_W + 1;  // weight product 0..2^32
  localparam int PROD_W   = VAL_W + WPROD_W;
  localparam int ACC_W    = PROD_W;

  // stream payload layout, lowest bit first
  localparam int S_ROW_LSB   = 0;
  localparam int S_COL_LSB   = S_ROW_LSB + WR_ROW_W;
  localparam int S_VAL_LSB   = S_COL_LSB + WR_COL_W;
  localparam int S_QROW_LSB  = S_VAL_LSB + VAL_W;
  localparam int S_QCOL_LSB  = S_QROW_LSB + COORD_W;
  localparam int S_TDATA_W   = 112;
  localparam int M_TDATA_W   = VAL_W;

  // configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int ROWS_REG_W = 11;
  localparam int COLS_REG_W = 8;

  // result buffer
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // register reset values
  localparam logic [31:0]           ROW_ORIGIN_RST   = 32'hFFFA_0000;
  localparam logic [31:0]           ROW_INV_STEP_RST = 32'd6553600;
  localparam logic [31:0]           COL_ORIGIN_RST   = 32'd328;
  localparam logic [31:0]           COL_INV_STEP_RST = 32'd13107200;
  localparam logic [ROWS_REG_W-1:0] ROWS_USED_RST    = 11'd1024;
  localparam logic [COLS_REG_W-1:0] COLS_USED_RST    = 8'd99;

  // register index codes
  typedef enum logic [2:0] {
    REG_ROW_ORIGIN   = 3'd0,
    REG_ROW_INV_STEP = 3'd1,
    REG_COL_ORIGIN   = 3'd2,
    REG_COL_INV_STEP = 3'd3,
    REG_ROWS_USED    = 3'd4,
    REG_COLS_USED    = 3'd5
  } reg_e;

  // command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

endpackage

@@ hw/rtl/bilinear_table_interpolator_core.sv @@
// bilinear_table_interpolator_core: grid memory with bilinear query datapath
// depends on bti_pkg
//
//   channel   dir  handshake                 carries
//   s_axis    in   tvalid/tready             cmd (tuser), entry write or query (tdata)
//   m_axis    out  tvalid/tready             interp_value (tdata)
//   apb       in   psel/penable/pwrite       six configuration registers
//
// a query holds the single-port grid memory for one read per corner,
// a write holds it for a single access; this port sets the sustained rate
// reset clears control and registers only; grid entries are undefined until written
// up to four results can wait at the output; a new query holds at the memory
// sequencer when that room is taken, and every transaction behind it waits too
module bilinear_table_interpolator_core #(
  parameter int MAX_ROWS = bti_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bti_pkg::MAX_COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // wr_row, wr_col, wr_value, query_row_coord, query_col_coord, zero pad
  input  logic [bti_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic                            s_axis_tuser,
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // interp_value
  output logic [bti_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bti_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bti_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bti_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import bti_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam logic [31:0]       MAX_ROWS_C = 32'(MAX_ROWS);
  localparam logic [31:0]       MAX_COLS_C = 32'(MAX_COLS);
  localparam logic [31:0]       MIN_USED   = 32'd2;
  localparam logic [WGT_W-1:0]  W_ONE      = WGT_W'(1 << FRAC_W);
  localparam logic [ACC_W-1:0]  RND_HALF   = ACC_W'(64'h8000_0000);

  // configuration registers
  logic [31:0]           row_origin_q, row_inv_q, col_origin_q, col_inv_q;
  logic [ROWS_REG_W-1:0] rows_used_q;
  logic [COLS_REG_W-1:0] cols_used_q;
  logic                  cfg_wr;
  reg_e                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_origin_q <= ROW_ORIGIN_RST;
      row_inv_q    <= ROW_INV_STEP_RST;
      col_origin_q <= COL_ORIGIN_RST;
      col_inv_q    <= COL_INV_STEP_RST;
      rows_used_q  <= ROWS_USED_RST;
      cols_used_q  <= COLS_USED_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROW_ORIGIN:   row_origin_q <= pwdata;
        REG_ROW_INV_STEP: row_inv_q    <= pwdata;
        REG_COL_ORIGIN:   col_origin_q <= pwdata;
        REG_COL_INV_STEP: col_inv_q    <= pwdata;
        REG_ROWS_USED:    rows_used_q  <= pwdata[ROWS_REG_W-1:0];
        REG_COLS_USED:    cols_used_q  <= pwdata[COLS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_ROW_ORIGIN:   prdata = row_origin_q;
      REG_ROW_INV_STEP: prdata = row_inv_q;
      REG_COL_ORIGIN:   prdata = col_origin_q;
      REG_COL_INV_STEP: prdata = col_inv_q;
      REG_ROWS_USED:    prdata = APB_DATA_W'(rows_used_q);
      REG_COLS_USED:    prdata = APB_DATA_W'(cols_used_q);
      default:          prdata = '0;
    endcase
  end

  // pipeline control
  logic s1_v_q, s2_v_q, s3_v_q;
  logic adv1, adv2, s1_free, s2_free, s3_free, s3_done;
  logic issue_rd, q_start, credit_ok, mem_we, push;
  logic [1:0] corner_q;
  logic [OUT_CNT_W-1:0] inflight_q, out_cnt_q;
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic pop, s_acc;

  // stage payloads
  cmd_e               s1_cmd_q, s2_cmd_q, s3_cmd_q;
  logic               s1_in_grid_q, s2_in_grid_q, s3_in_grid_q;
  logic [ADDR_W-1:0]  s1_waddr_q, s2_waddr_q, s3_waddr_q;
  logic [VAL_W-1:0]   s1_wval_q, s2_wval_q, s3_wval_q;
  logic [31:0]        s1_dr_q, s1_dc_q;
  logic [IDX_W-1:0]   s2_ir_q, s2_ic_q;
  logic [ROW_W-1:0]   s3_r0_q;
  logic [COL_W-1:0]   s3_c0_q;
  logic [WGT_W-1:0]   s3_wr1_q, s3_wc1_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    credit_ok = ({1'b0, inflight_q} + {1'b0, out_cnt_q}) < (OUT_CNT_W + 1)'(OUT_DEPTH);
    issue_rd  = s3_v_q && (s3_cmd_q == CMD_QUERY) && ((corner_q != 2'd0) || credit_ok);
    q_start   = issue_rd && (corner_q == 2'd0);
    mem_we    = s3_v_q && (s3_cmd_q == CMD_WRITE) && s3_in_grid_q;
    s3_done   = s3_v_q && ((s3_cmd_q == CMD_WRITE) || (issue_rd && (corner_q == 2'd3)));
    s3_free   = !s3_v_q || s3_done;
    adv2      = s2_v_q && s3_free;
    s2_free   = !s2_v_q || adv2;
    adv1      = s1_v_q && s2_free;
    s1_free   = !s1_v_q || adv1;
  end

  assign s_axis_tready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      corner_q <= 2'd0;
    end else begin
      if (s1_free) s1_v_q <= s_acc;
      if (s2_free) s2_v_q <= adv1;
      if (s3_free) s3_v_q <= adv2;
      if (issue_rd) corner_q <= corner_q + 2'd1;
    end
  end

  // stage 1: write address check, coordinate offsets
  logic [32:0] d_row, d_col;
  logic [31:0] wr_row_ext, wr_col_ext;

  always_comb begin
    d_row = {s_axis_tdata[S_QROW_LSB+COORD_W-1], s_axis_tdata[S_QROW_LSB +: COORD_W]}
          - {row_origin_q[31], row_origin_q};
    d_col = {s_axis_tdata[S_QCOL_LSB+COORD_W-1], s_axis_tdata[S_QCOL_LSB +: COORD_W]}
          - {col_origin_q[31], col_origin_q};
    wr_row_ext = 32'(s_axis_tdata[S_ROW_LSB +: WR_ROW_W]);
    wr_col_ext = 32'(s_axis_tdata[S_COL_LSB +: WR_COL_W]);
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && s_acc) begin
      s1_cmd_q     <= cmd_e'(s_axis_tuser);
      s1_in_grid_q <= (wr_row_ext < MAX_ROWS_C) && (wr_col_ext < MAX_COLS_C);
      s1_waddr_q   <= {ROW_W'(s_axis_tdata[S_ROW_LSB +: WR_ROW_W]),
                       COL_W'(s_axis_tdata[S_COL_LSB +: WR_COL_W])};
      s1_wval_q    <= s_axis_tdata[S_VAL_LSB +: VAL_W];
      // non-positive offset gives index zero
      s1_dr_q      <= (!d_row[32] && (d_row != '0)) ? d_row[31:0] : '0;
      s1_dc_q      <= (!d_col[32] && (d_col != '0)) ? d_col[31:0] : '0;
    end
  end

  // stage 2: scale offsets by inverse step
  logic [63:0] pr_row, pr_col;
  assign pr_row = 64'(s1_dr_q) * 64'(row_inv_q);
  assign pr_col = 64'(s1_dc_q) * 64'(col_inv_q);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_cmd_q     <= s1_cmd_q;
      s2_in_grid_q <= s1_in_grid_q;
      s2_waddr_q   <= s1_waddr_q;
      s2_wval_q    <= s1_wval_q;
      s2_ir_q      <= pr_row[FRAC_W +: IDX_W];
      s2_ic_q      <= pr_col[FRAC_W +: IDX_W];
    end
  end

  // stage 3: clamp, pick bracketing corners and upper weights
  logic [31:0]      rows_sat, cols_sat;
  logic [IDX_W-1:0] lim_r, lim_c, ir_cl, ic_cl;
  logic [ROW_W-1:0] ip_r, r0_d;
  logic [COL_W-1:0] ip_c, c0_d;
  logic [FRAC_W-1:0] fr_r, fr_c;
  logic [WGT_W-1:0] wr1_d, wc1_d;

  always_comb begin
    // used counts held inside [2, max]
    priority if (32'(rows_used_q) < MIN_USED) rows_sat = MIN_USED;
    else if (32'(rows_used_q) > MAX_ROWS_C)   rows_sat = MAX_ROWS_C;
    else                                      rows_sat = 32'(rows_used_q);
    priority if (32'(cols_used_q) < MIN_USED) cols_sat = MIN_USED;
    else if (32'(cols_used_q) > MAX_COLS_C)   cols_sat = MAX_COLS_C;
    else                                      cols_sat = 32'(cols_used_q);

    lim_r = IDX_W'({ROW_W'(rows_sat - 32'd1), {FRAC_W{1'b0}}});
    lim_c = IDX_W'({COL_W'(cols_sat - 32'd1), {FRAC_W{1'b0}}});
    ir_cl = (s2_ir_q > lim_r) ? lim_r : s2_ir_q;
    ic_cl = (s2_ic_q > lim_c) ? lim_c : s2_ic_q;
    ip_r  = ir_cl[FRAC_W +: ROW_W];
    ip_c  = ic_cl[FRAC_W +: COL_W];
    fr_r  = ir_cl[FRAC_W-1:0];
    fr_c  = ic_cl[FRAC_W-1:0];

    // nonzero exact grid point: pair shifts inward, full weight on the upper index
    if (fr_r != '0) begin
      r0_d  = ip_r;
      wr1_d = {1'b0, fr_r};
    end else if (ip_r != '0) begin
      r0_d  = ip_r - ROW_W'(1);
      wr1_d = W_ONE;
    end else begin
      r0_d  = '0;
      wr1_d = '0;
    end
    if (fr_c != '0) begin
      c0_d  = ip_c;
      wc1_d = {1'b0, fr_c};
    end else if (ip_c != '0) begin
      c0_d  = ip_c - COL_W'(1);
      wc1_d = W_ONE;
    end else begin
      c0_d  = '0;
      wc1_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s3_cmd_q     <= s2_cmd_q;
      s3_in_grid_q <= s2_in_grid_q;
      s3_waddr_q   <= s2_waddr_q;
      s3_wval_q    <= s2_wval_q;
      s3_r0_q      <= r0_d;
      s3_c0_q      <= c0_d;
      s3_wr1_q     <= wr1_d;
      s3_wc1_q     <= wc1_d;
    end
  end

  // memory sequencer: corners in order, one access a cycle unless out of credit
  logic [ADDR_W-1:0] mem_addr;
  logic [WGT_W-1:0]  w_row, w_col;
  logic [2*WGT_W-1:0] wprod_full;

  always_comb begin
    if (s3_cmd_q == CMD_WRITE) begin
      mem_addr = s3_waddr_q;
    end else begin
      mem_addr = {s3_r0_q + ROW_W'(corner_q[0]), s3_c0_q + COL_W'(corner_q[1])};
    end
    w_row      = corner_q[0] ? s3_wr1_q : (W_ONE - s3_wr1_q);
    w_col      = corner_q[1] ? s3_wc1_q : (W_ONE - s3_wc1_q);
    wprod_full = (2*WGT_W)'(w_row) * (2*WGT_W)'(w_col);
  end

  // grid memory, single port, registered read
  logic [VAL_W-1:0] grid_mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= s3_wval_q;
    end else if (issue_rd) begin
      rdata_q <= grid_mem[mem_addr];
    end
  end

  // blend: weight the entry, then accumulate with rounding bias
  logic               rd_v_q, rd_first_q, rd_last_q;
  logic [WPROD_W-1:0] wprod_q;
  logic               pr_v_q, pr_first_q, pr_last_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   acc_q, acc_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      pr_v_q <= 1'b0;
    end else begin
      rd_v_q <= issue_rd;
      pr_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_rd) begin
      rd_first_q <= (corner_q == 2'd0);
      rd_last_q  <= (corner_q == 2'd3);
      wprod_q    <= wprod_full[WPROD_W-1:0];
    end
    if (rd_v_q) begin
      pr_first_q <= rd_first_q;
      pr_last_q  <= rd_last_q;
      prod_q     <= PROD_W'(rdata_q) * PROD_W'(wprod_q);
    end
    if (pr_v_q) begin
      acc_q <= acc_sum;
    end
  end

  assign acc_sum = (pr_first_q ? RND_HALF : acc_q) + prod_q;
  assign push    = pr_v_q && pr_last_q;

  // result buffer and query credit count
  logic [VAL_W-1:0] out_buf_q [OUT_DEPTH];

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (out_cnt_q != '0);
  assign m_axis_tdata  = out_buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) out_buf_q[wr_ptr_q] <= acc_sum[2*FRAC_W +: VAL_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      out_cnt_q  <= '0;
      inflight_q <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      out_cnt_q  <= out_cnt_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
      inflight_q <= inflight_q + OUT_CNT_W'(q_start) - OUT_CNT_W'(push);
    end
  end

endmodule

@@ hw/rtl/bti_checker.sv @@
// bti_checker: port-level checks on bilinear_table_interpolator_core, bound to it
// depends on bti_pkg and the top level's port list
module bti_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bti_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [bti_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [bti_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [bti_pkg::APB_DATA_W-1:0]  prdata
);
  import bti_pkg::*;

  // no result shows while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // a waiting result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped before transaction");

  // a waiting result keeps its value
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  // row origin reads back what was last written
  a_origin_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[4:2] == REG_ROW_ORIGIN)
    |=> (paddr[4:2] != REG_ROW_ORIGIN) || (prdata == $past(pwdata)))
    else $error("row origin readback mismatch");

endmodule

bind bilinear_table_interpolator_core bti_checker u_bti_checker (.*);
